@@ rtl/obm_pkg.sv @@
`timescale 1ns / 1ps
package obm_pkg;

   localparam int BOOK_DEPTH = 16;
   localparam int IDX_W = $clog2(BOOK_DEPTH);
   localparam int CNT_W = $clog2(BOOK_DEPTH + 1);

   typedef enum logic [1:0] {
      REQ_ADD_BUY  = 2'd0,
      REQ_ADD_SELL = 2'd1,
      REQ_MATCH    = 2'd2,
      REQ_UNUSED   = 2'd3
   } req_code_type;

   typedef enum logic [1:0] {
      ST_ACCEPTED = 2'd0,
      ST_FULL     = 2'd1,
      ST_TRADE    = 2'd2,
      ST_NO_TRADE = 2'd3
   } status_code_type;

   typedef enum logic [1:0] {
      CMD_BUY,
      CMD_SELL,
      CMD_MATCH
   } cmd_op_type;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [31:0] order_id;
      logic [15:0] symbol;
      logic [31:0] price;
      logic [23:0] quantity;
      logic [31:0] timestamp;
   } req_item_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] buy_order_id;
      logic [31:0] sell_order_id;
      logic [15:0] trade_symbol;
      logic [23:0] trade_quantity;
      logic [31:0] trade_price;
      logic        last;
   } rsp_item_type;

   typedef struct packed {
      logic [31:0] id;
      logic [15:0] symbol;
      logic [31:0] price;
      logic [23:0] qty;
      logic [31:0] stamp;
   } entry_type;

   typedef struct packed {
      cmd_op_type op;
      entry_type  entry;
   } cmd_type;

   // a strictly ahead of b in book priority
   function automatic logic goes_before(entry_type a, entry_type b, logic high_first);
      logic r;
      if (a.price == b.price) begin
         r = a.stamp < b.stamp;
      end else if (high_first) begin
         r = a.price > b.price;
      end else begin
         r = a.price < b.price;
      end
      return r;
   endfunction

endpackage

@@ rtl/obm_front.sv @@
`timescale 1ns / 1ps
module obm_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  obm_pkg::req_item_type req_item,
   output logic                 cmd_valid,
   output obm_pkg::cmd_type     cmd,
   input  logic                 cmd_pop
);
   import obm_pkg::*;

   cmd_type    q_ff [2];
   logic       wr_ff, wr_in;
   logic       rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   cmd_type    new_cmd;
   logic       push;

   always_comb begin
      new_cmd.entry = '{id: req_item.order_id, symbol: req_item.symbol,
                        price: req_item.price, qty: req_item.quantity,
                        stamp: req_item.timestamp};
      push = 1'b0;
      new_cmd.op = CMD_MATCH;
      unique case (req_code_type'(req_item.req_type))
         REQ_ADD_BUY: begin
            new_cmd.op = CMD_BUY;
            push = start && !busy;
         end
         REQ_ADD_SELL: begin
            new_cmd.op = CMD_SELL;
            push = start && !busy;
         end
         REQ_MATCH: begin
            push = start && !busy;
         end
         REQ_UNUSED: begin
            push = 1'b0;
         end
      endcase
   end

   assign busy      = (cnt_ff == 2'd2);
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd       = q_ff[rd_ff];

   always_comb begin
      wr_in  = push ? ~wr_ff : wr_ff;
      rd_in  = cmd_pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(cmd_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         q_ff[wr_ff] <= new_cmd;
      end
   end

endmodule

@@ rtl/obm_back.sv @@
`timescale 1ns / 1ps
module obm_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  cmd_valid,
   input  obm_pkg::cmd_type      cmd,
   output logic                  cmd_pop,
   output logic                  rsp_valid,
   output obm_pkg::rsp_item_type rsp_item
);
   import obm_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SORT,
      S_MATCH,
      S_FINAL,
      S_COMPACT
   } state_type;

   state_type    state_ff, state_in;
   entry_type    buy_ff [BOOK_DEPTH];
   entry_type    buy_in [BOOK_DEPTH];
   entry_type    sell_ff [BOOK_DEPTH];
   entry_type    sell_in [BOOK_DEPTH];
   entry_type    buy_sorted [BOOK_DEPTH];
   entry_type    sell_sorted [BOOK_DEPTH];
   logic [CNT_W-1:0] buy_cnt_ff, buy_cnt_in, sell_cnt_ff, sell_cnt_in;
   logic [IDX_W-1:0] pass_ff, pass_in;
   logic [IDX_W-1:0] i_ff, i_in, j_ff, j_in;
   logic [CNT_W-1:0] br_ff, br_in, bw_ff, bw_in, sr_ff, sr_in, sw_ff, sw_in;
   logic         pend_ff, pend_in;
   rsp_item_type pend_item_ff, pend_item_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_ff, rsp_in;
   entry_type    b, s;
   logic         hit;
   logic [23:0]  q;

   // odd-even transposition pass, stable since only strict order swaps
   always_comb begin
      buy_sorted  = buy_ff;
      sell_sorted = sell_ff;
      for (int k = 0; k < BOOK_DEPTH - 1; k++) begin
         if ((k % 2) == int'(pass_ff[0])) begin
            if (CNT_W'(k + 1) < buy_cnt_ff &&
                goes_before(buy_ff[k+1], buy_ff[k], 1'b1)) begin
               buy_sorted[k]   = buy_ff[k+1];
               buy_sorted[k+1] = buy_ff[k];
            end
            if (CNT_W'(k + 1) < sell_cnt_ff &&
                goes_before(sell_ff[k+1], sell_ff[k], 1'b0)) begin
               sell_sorted[k]   = sell_ff[k+1];
               sell_sorted[k+1] = sell_ff[k];
            end
         end
      end
   end

   assign b   = buy_ff[i_ff];
   assign s   = sell_ff[j_ff];
   assign hit = (b.symbol == s.symbol) && (b.price >= s.price) &&
                (b.qty != 24'd0) && (s.qty != 24'd0);
   assign q   = (b.qty < s.qty) ? b.qty : s.qty;

   assign cmd_pop = (state_ff == S_IDLE) && cmd_valid;

   always_comb begin
      state_in     = state_ff;
      buy_in       = buy_ff;
      sell_in      = sell_ff;
      buy_cnt_in   = buy_cnt_ff;
      sell_cnt_in  = sell_cnt_ff;
      pass_in      = pass_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      br_in        = br_ff;
      bw_in        = bw_ff;
      sr_in        = sr_ff;
      sw_in        = sw_ff;
      pend_in      = pend_ff;
      pend_item_in = pend_item_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               rsp_in      = '0;
               rsp_in.last = 1'b1;
               unique case (cmd.op)
                  CMD_BUY: begin
                     rsp_valid_in = 1'b1;
                     if (buy_cnt_ff == CNT_W'(BOOK_DEPTH)) begin
                        rsp_in.status = ST_FULL;
                     end else begin
                        rsp_in.status = ST_ACCEPTED;
                        buy_in[buy_cnt_ff[IDX_W-1:0]] = cmd.entry;
                        buy_cnt_in = buy_cnt_ff + 1'b1;
                     end
                  end
                  CMD_SELL: begin
                     rsp_valid_in = 1'b1;
                     if (sell_cnt_ff == CNT_W'(BOOK_DEPTH)) begin
                        rsp_in.status = ST_FULL;
                     end else begin
                        rsp_in.status = ST_ACCEPTED;
                        sell_in[sell_cnt_ff[IDX_W-1:0]] = cmd.entry;
                        sell_cnt_in = sell_cnt_ff + 1'b1;
                     end
                  end
                  CMD_MATCH: begin
                     pass_in  = '0;
                     state_in = S_SORT;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_SORT: begin
            buy_in  = buy_sorted;
            sell_in = sell_sorted;
            pass_in = pass_ff + 1'b1;
            if (pass_ff == IDX_W'(BOOK_DEPTH - 1)) begin
               i_in    = '0;
               j_in    = '0;
               pend_in = 1'b0;
               if (buy_cnt_ff == '0 || sell_cnt_ff == '0) begin
                  state_in = S_FINAL;
               end else begin
                  state_in = S_MATCH;
               end
            end
         end
         S_MATCH: begin
            if (hit) begin
               buy_in[i_ff].qty  = b.qty - q;
               sell_in[j_ff].qty = s.qty - q;
               if (pend_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = pend_item_ff;
               end
               pend_in      = 1'b1;
               pend_item_in = '{status: ST_TRADE, buy_order_id: b.id,
                                sell_order_id: s.id, trade_symbol: b.symbol,
                                trade_quantity: q, trade_price: s.price,
                                last: 1'b0};
            end
            if (CNT_W'(j_ff) + 1'b1 == sell_cnt_ff) begin
               j_in = '0;
               if (CNT_W'(i_ff) + 1'b1 == buy_cnt_ff) begin
                  state_in = S_FINAL;
               end else begin
                  i_in = i_ff + 1'b1;
               end
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         S_FINAL: begin
            // final beat is held back until the walk is over so it can carry last
            rsp_valid_in = 1'b1;
            if (pend_ff) begin
               rsp_in      = pend_item_ff;
               rsp_in.last = 1'b1;
            end else begin
               rsp_in        = '0;
               rsp_in.status = ST_NO_TRADE;
               rsp_in.last   = 1'b1;
            end
            br_in    = '0;
            bw_in    = '0;
            sr_in    = '0;
            sw_in    = '0;
            state_in = S_COMPACT;
         end
         S_COMPACT: begin
            if (br_ff >= buy_cnt_ff && sr_ff >= sell_cnt_ff) begin
               buy_cnt_in  = bw_ff;
               sell_cnt_in = sw_ff;
               state_in    = S_IDLE;
            end else begin
               if (br_ff < buy_cnt_ff) begin
                  br_in = br_ff + 1'b1;
                  if (buy_ff[br_ff[IDX_W-1:0]].qty != 24'd0) begin
                     buy_in[bw_ff[IDX_W-1:0]] = buy_ff[br_ff[IDX_W-1:0]];
                     bw_in = bw_ff + 1'b1;
                  end
               end
               if (sr_ff < sell_cnt_ff) begin
                  sr_in = sr_ff + 1'b1;
                  if (sell_ff[sr_ff[IDX_W-1:0]].qty != 24'd0) begin
                     sell_in[sw_ff[IDX_W-1:0]] = sell_ff[sr_ff[IDX_W-1:0]];
                     sw_in = sw_ff + 1'b1;
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         buy_cnt_ff   <= '0;
         sell_cnt_ff  <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         buy_cnt_ff   <= buy_cnt_in;
         sell_cnt_ff  <= sell_cnt_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      buy_ff       <= buy_in;
      sell_ff      <= sell_in;
      pass_ff      <= pass_in;
      i_ff         <= i_in;
      j_ff         <= j_in;
      br_ff        <= br_in;
      bw_ff        <= bw_in;
      sr_ff        <= sr_in;
      sw_ff        <= sw_in;
      pend_item_ff <= pend_item_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

@@ rtl/order_book_matcher.sv @@
`timescale 1ns / 1ps
// Limit order book with price-time priority matching, BOOK_DEPTH orders per side.
// Requests are taken when start is high and busy is low; a two-beat queue sits
// in front of the book engine, so busy rises only when two requests wait. Each
// result appears on rsp_item for one cycle with rsp_valid high and must be taken
// then. A match runs an odd-even transposition sort of both sides, then walks
// every buy/sell pair (skipped if either side is empty), then a closing state,
// then a compaction that drops filled orders. Each trade beat is held until
// the next trade is found or the walk ends; the last one is marked by last.
module order_book_matcher (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  obm_pkg::req_item_type req_item,
   output logic                  rsp_valid,
   output obm_pkg::rsp_item_type rsp_item
);
   import obm_pkg::*;

   logic    cmd_valid;
   logic    cmd_pop;
   cmd_type cmd;

   obm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   obm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

endmodule

@@ rtl/obm_checker.sv @@
`timescale 1ns / 1ps
module obm_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  start,
   input logic                  busy,
   input obm_pkg::rsp_item_type rsp_item,
   input logic                  rsp_valid
);
   import obm_pkg::*;

   a_quiet_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid) else $error("result beat straight after reset");

   a_single_beat_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.status != ST_TRADE |-> rsp_item.last)
      else $error("non-trade result without last");

   a_trade_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.status == ST_TRADE |-> rsp_item.trade_quantity != 24'd0)
      else $error("trade of zero quantity");

   a_plain_fields_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.status != ST_TRADE |->
         rsp_item.trade_quantity == 24'd0 && rsp_item.trade_price == 32'd0)
      else $error("trade fields set on a non-trade result");

   // the queue only fills up behind a request beat
   a_busy_after_request: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start))
      else $error("busy rose without a request beat");

endmodule

bind order_book_matcher obm_checker u_obm_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_item  (rsp_item),
   .rsp_valid (rsp_valid)
);
